// ----- sv/ask_bid_order_matcher_top_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the order matcher
// Shared property forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef ASK_BID_ORDER_MATCHER_TOP_DEFINES_SVH
`define ASK_BID_ORDER_MATCHER_TOP_DEFINES_SVH

// same-cycle implication
`define ABOM_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ABOM_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- sv/abom_pkg.sv -----
// ----------------------------------------------------------------------------
// abom_pkg
// Types and constants of the order matcher.
// ----------------------------------------------------------------------------
package abom_pkg;

  localparam int SideDepth = 16;
  localparam int IdxW      = $clog2(SideDepth);
  localparam int CntW      = $clog2(SideDepth + 1);
  localparam int ValW      = 32;
  localparam int ProdW     = 16;
  localparam int InDataW   = 120;
  localparam int OutDataW  = 72;
  localparam int CfgIdxW   = 1;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PRODUCT = 1'b0,
    CFG_TIME    = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic            sim;
    logic [ValW-1:0] amount;
    logic [ValW-1:0] price;
  } entry_t;

  typedef struct packed {
    logic            lt;
    logic            gt;
    logic [ValW-1:0] a_minus_b;
    logic [ValW-1:0] b_minus_a;
  } alu_res_t;

endpackage

// ----- sv/abom_alu.sv -----
// ----------------------------------------------------------------------------
// abom_alu
// Shared compare and subtract unit for insertion and matching.
// ----------------------------------------------------------------------------
module abom_alu (
  input  logic [abom_pkg::ValW-1:0] a_i,
  input  logic [abom_pkg::ValW-1:0] b_i,
  output abom_pkg::alu_res_t        res_o
);
  import abom_pkg::*;

  always_comb begin
    res_o.lt        = a_i < b_i;
    res_o.gt        = a_i > b_i;
    res_o.a_minus_b = a_i - b_i;
    res_o.b_minus_a = b_i - a_i;
  end

endmodule

// ----- sv/ask_bid_order_matcher_top.sv -----
// ----------------------------------------------------------------------------
// ask_bid_order_matcher_top
// Price-priority order book: sorted load of a batch, then ask/bid matching.
// ----------------------------------------------------------------------------
// Input items (s_axis) carry one order each; tlast marks the batch end.
// Orders with product/time codes equal to the config registers are inserted
// into a sorted side book (asks ascending, bids descending, ties in arrival
// order); other orders are ignored. A full side drops the order and sets
// the overflow flag.
// Insertion walks the side from the top, one entry at a time through the
// shared compare unit, a read state then a compare-and-write state. After
// the last order each ask is walked against the bids, each sale an output
// item (m_axis); the final item has tlast, and a batch without sales yields
// one invalid item.
// s_axis_tready is high only while idle. A stalled receiver holds the
// output register and the walk waits on it.
// Reset empties the book and clears both config registers.
// ----------------------------------------------------------------------------
module ask_bid_order_matcher_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [abom_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [abom_pkg::ValW-1:0]        cfg_data_i,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // order_price, order_amount, order_sim_user, product_code, time_code, pad
  input  logic [abom_pkg::InDataW-1:0]     s_axis_tdata,
  // order_side
  input  logic                             s_axis_tuser,
  // last_order
  input  logic                             s_axis_tlast,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // sale_price, sale_amount, sale_sim_user, book_overflow, pad
  output logic [abom_pkg::OutDataW-1:0]    m_axis_tdata,
  // sale_valid, sale_kind
  output logic [1:0]                       m_axis_tuser,
  // last_sale
  output logic                             m_axis_tlast
);
  import abom_pkg::*;

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_INSRD = 9'b000000010,
    ST_INSCM = 9'b000000100,
    ST_MASK  = 9'b000001000,
    ST_MALD  = 9'b000010000,
    ST_MBID  = 9'b000100000,
    ST_MCMP  = 9'b001000000,
    ST_MSALE = 9'b010000000,
    ST_MFIN  = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  logic [ProdW-1:0] sel_prod_q;
  logic [ValW-1:0]  sel_time_q;

  entry_t ask_mem [SideDepth];
  entry_t bid_mem [SideDepth];
  entry_t ask_rd_q, bid_rd_q;

  logic [CntW-1:0] ask_cnt_q, ask_cnt_d, bid_cnt_q, bid_cnt_d;
  logic            ovf_q, ovf_d;

  entry_t          new_q, new_d;
  logic            new_side_q, new_side_d, new_last_q, new_last_d;
  logic [CntW-1:0] idx_q, idx_d;
  logic [CntW-1:0] a_q, a_d, b_q, b_d;
  logic [ValW-1:0] rem_q, rem_d;

  logic            pend_v_q, pend_v_d;
  logic [ValW-1:0] pend_price_q, pend_price_d, pend_amt_q, pend_amt_d;
  logic            pend_kind_q, pend_kind_d, pend_sim_q, pend_sim_d;

  logic            out_v_q, out_v_d;
  logic            out_sv_q, out_sv_d, out_kind_q, out_kind_d, out_sim_q, out_sim_d;
  logic            out_ovf_q, out_ovf_d, out_last_q, out_last_d;
  logic [ValW-1:0] out_price_q, out_price_d, out_amt_q, out_amt_d;

  logic            ask_we, bid_we, ask_re, bid_re;
  logic [IdxW-1:0] wr_addr, rd_addr;
  entry_t          wr_data;

  logic [ValW-1:0] alu_a, alu_b;
  alu_res_t        alu;

  logic            in_acc, match, cur_full, shift;
  logic [CntW-1:0] cur_cnt;

  abom_alu u_alu (.a_i(alu_a), .b_i(alu_b), .res_o(alu));

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign match         = (s_axis_tdata[80:65] == sel_prod_q)
                       && (s_axis_tdata[112:81] == sel_time_q);
  assign cur_cnt       = new_side_q ? bid_cnt_q : ask_cnt_q;
  assign cur_full      = (s_axis_tuser ? bid_cnt_q : ask_cnt_q) == CntW'(SideDepth);
  assign shift         = new_side_q ? alu.lt : alu.gt;

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {6'd0, out_ovf_q, out_sim_q, out_amt_q, out_price_q};
  assign m_axis_tuser  = {out_kind_q, out_sv_q};
  assign m_axis_tlast  = out_last_q;

  always_comb begin
    state_d      = state_q;
    ask_cnt_d    = ask_cnt_q;
    bid_cnt_d    = bid_cnt_q;
    ovf_d        = ovf_q;
    new_d        = new_q;
    new_side_d   = new_side_q;
    new_last_d   = new_last_q;
    idx_d        = idx_q;
    a_d          = a_q;
    b_d          = b_q;
    rem_d        = rem_q;
    pend_v_d     = pend_v_q;
    pend_price_d = pend_price_q;
    pend_amt_d   = pend_amt_q;
    pend_kind_d  = pend_kind_q;
    pend_sim_d   = pend_sim_q;
    out_v_d      = out_v_q && !m_axis_tready;
    out_sv_d     = out_sv_q;
    out_kind_d   = out_kind_q;
    out_sim_d    = out_sim_q;
    out_ovf_d    = out_ovf_q;
    out_last_d   = out_last_q;
    out_price_d  = out_price_q;
    out_amt_d    = out_amt_q;
    ask_we       = 1'b0;
    bid_we       = 1'b0;
    ask_re       = 1'b0;
    bid_re       = 1'b0;
    wr_addr      = idx_q[IdxW-1:0];
    rd_addr      = idx_q[IdxW-1:0] - 1'b1;
    wr_data      = new_q;
    alu_a        = bid_rd_q.price;
    alu_b        = ask_rd_q.price;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          new_d.price  = s_axis_tdata[31:0];
          new_d.amount = s_axis_tdata[63:32];
          new_d.sim    = s_axis_tdata[64];
          new_side_d   = s_axis_tuser;
          new_last_d   = s_axis_tlast;
          idx_d        = s_axis_tuser ? bid_cnt_q : ask_cnt_q;
          a_d          = '0;
          if (match && !cur_full) begin
            state_d = ST_INSRD;
          end else begin
            if (match) ovf_d = 1'b1;
            state_d = s_axis_tlast ? ST_MASK : ST_IDLE;
          end
        end
      end
      ST_INSRD: begin
        if (idx_q == '0) begin
          ask_we  = !new_side_q;
          bid_we  = new_side_q;
          if (new_side_q) bid_cnt_d = cur_cnt + 1'b1;
          else            ask_cnt_d = cur_cnt + 1'b1;
          state_d = new_last_q ? ST_MASK : ST_IDLE;
        end else begin
          ask_re  = !new_side_q;
          bid_re  = new_side_q;
          state_d = ST_INSCM;
        end
      end
      ST_INSCM: begin
        alu_a = new_side_q ? bid_rd_q.price : ask_rd_q.price;
        alu_b = new_q.price;
        ask_we = !new_side_q;
        bid_we = new_side_q;
        if (shift) begin
          wr_data = new_side_q ? bid_rd_q : ask_rd_q;
          idx_d   = idx_q - 1'b1;
          state_d = ST_INSRD;
        end else begin
          if (new_side_q) bid_cnt_d = cur_cnt + 1'b1;
          else            ask_cnt_d = cur_cnt + 1'b1;
          state_d = new_last_q ? ST_MASK : ST_IDLE;
        end
      end
      ST_MASK: begin
        rd_addr = a_q[IdxW-1:0];
        if (a_q == ask_cnt_q) begin
          state_d = ST_MFIN;
        end else begin
          ask_re  = 1'b1;
          state_d = ST_MALD;
        end
      end
      ST_MALD: begin
        rem_d   = ask_rd_q.amount;
        b_d     = '0;
        state_d = ST_MBID;
      end
      ST_MBID: begin
        rd_addr = b_q[IdxW-1:0];
        if (b_q == bid_cnt_q || rem_q == '0) begin
          a_d     = a_q + 1'b1;
          state_d = ST_MASK;
        end else begin
          bid_re  = 1'b1;
          state_d = ST_MCMP;
        end
      end
      ST_MCMP: begin
        if (bid_rd_q.amount != '0 && !alu.lt) begin
          state_d = ST_MSALE;
        end else begin
          b_d     = b_q + 1'b1;
          state_d = ST_MBID;
        end
      end
      ST_MSALE: begin
        alu_a = bid_rd_q.amount;
        alu_b = rem_q;
        if (!pend_v_q || !out_v_q) begin
          if (pend_v_q) begin
            out_v_d     = 1'b1;
            out_sv_d    = 1'b1;
            out_price_d = pend_price_q;
            out_amt_d   = pend_amt_q;
            out_kind_d  = pend_kind_q;
            out_sim_d   = pend_sim_q;
            out_ovf_d   = ovf_q;
            out_last_d  = 1'b0;
          end
          pend_v_d     = 1'b1;
          pend_price_d = ask_rd_q.price;
          pend_amt_d   = alu.lt ? bid_rd_q.amount : rem_q;
          pend_kind_d  = bid_rd_q.sim && !ask_rd_q.sim;
          pend_sim_d   = bid_rd_q.sim || ask_rd_q.sim;
          rem_d        = alu.lt ? alu.b_minus_a : '0;
          bid_we       = 1'b1;
          wr_addr      = b_q[IdxW-1:0];
          wr_data      = bid_rd_q;
          wr_data.amount = alu.lt ? '0 : alu.a_minus_b;
          b_d          = b_q + 1'b1;
          state_d      = ST_MBID;
        end
      end
      ST_MFIN: begin
        if (!out_v_q) begin
          out_v_d     = 1'b1;
          out_sv_d    = pend_v_q;
          out_price_d = pend_v_q ? pend_price_q : '0;
          out_amt_d   = pend_v_q ? pend_amt_q : '0;
          out_kind_d  = pend_v_q && pend_kind_q;
          out_sim_d   = pend_v_q && pend_sim_q;
          out_ovf_d   = ovf_q;
          out_last_d  = 1'b1;
          pend_v_d    = 1'b0;
          ask_cnt_d   = '0;
          bid_cnt_d   = '0;
          ovf_d       = 1'b0;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ask_we) ask_mem[wr_addr] <= wr_data;
    if (ask_re) ask_rd_q <= ask_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (bid_we) bid_mem[wr_addr] <= wr_data;
    if (bid_re) bid_rd_q <= bid_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      sel_prod_q <= '0;
      sel_time_q <= '0;
      ask_cnt_q  <= '0;
      bid_cnt_q  <= '0;
      ovf_q      <= 1'b0;
      pend_v_q   <= 1'b0;
      out_v_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      ask_cnt_q <= ask_cnt_d;
      bid_cnt_q <= bid_cnt_d;
      ovf_q     <= ovf_d;
      pend_v_q  <= pend_v_d;
      out_v_q   <= out_v_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CFG_PRODUCT: sel_prod_q <= cfg_data_i[ProdW-1:0];
          CFG_TIME:    sel_time_q <= cfg_data_i;
          default:     sel_time_q <= sel_time_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    new_q        <= new_d;
    new_side_q   <= new_side_d;
    new_last_q   <= new_last_d;
    idx_q        <= idx_d;
    a_q          <= a_d;
    b_q          <= b_d;
    rem_q        <= rem_d;
    pend_price_q <= pend_price_d;
    pend_amt_q   <= pend_amt_d;
    pend_kind_q  <= pend_kind_d;
    pend_sim_q   <= pend_sim_d;
    out_sv_q     <= out_sv_d;
    out_kind_q   <= out_kind_d;
    out_sim_q    <= out_sim_d;
    out_ovf_q    <= out_ovf_d;
    out_last_q   <= out_last_d;
    out_price_q  <= out_price_d;
    out_amt_q    <= out_amt_d;
  end

endmodule

// ----- sv/abom_checker.sv -----
// ----------------------------------------------------------------------------
// abom_checker
// Port-level checks of the order matcher, bound to the top level.
// ----------------------------------------------------------------------------
`include "ask_bid_order_matcher_top_defines.svh"

module abom_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        s_axis_tlast,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [71:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  `ABOM_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
  `ABOM_ASSERT_NEXT(a_busy_after_last, clk_i, rst_ni, s_axis_tvalid && s_axis_tready && s_axis_tlast, !s_axis_tready)
  `ABOM_ASSERT_IMPL(a_nosale_last, clk_i, rst_ni, m_axis_tvalid && !m_axis_tuser[0], m_axis_tlast)
  `ABOM_ASSERT_IMPL(a_nosale_zero, clk_i, rst_ni, m_axis_tvalid && !m_axis_tuser[0], m_axis_tdata[64:0] == '0)

endmodule

bind ask_bid_order_matcher_top abom_checker u_abom_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
